// File: hdl/otb_pkg.sv
// Shared types and constants for the Otsu threshold binarizer.
package otb_pkg;

   localparam logic CMD_HIST  = 1'b0;
   localparam logic CMD_CLASS = 1'b1;

   localparam logic KIND_THRESHOLD = 1'b0;
   localparam logic KIND_PIXEL     = 1'b1;

   localparam logic [7:0] WHITE_LEVEL = 8'd255;

   typedef struct packed {
      logic       command;
      logic [7:0] pixel;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] threshold_level;
      logic [7:0] binary_pixel;
   } rsp_item_type;

endpackage

// File: hdl/otb_front.sv
// Front end: accepts input items into a short queue for the back end.
module otb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  otb_pkg::req_item_type req_item,
   output logic                  q_valid,
   output otb_pkg::req_item_type q_item,
   input  logic                  q_take
);
   import otb_pkg::*;

   // two-entry queue
   req_item_type mem_ff [2];
   logic         wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         do_push, do_pop;

   assign req_full = (cnt_ff == 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = mem_ff[rp_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_take && q_valid;

   always_comb begin
      wp_in  = do_push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= req_item;
      end
   end
endmodule

// File: hdl/otb_back.sv
// Back end: histogram build, threshold search, clear sweep and classify.
module otb_back #(
   parameter int MAX_PIXEL_BITS = 20,
   parameter int GRAY_LEVELS    = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  otb_pkg::req_item_type q_item,
   output logic                  q_take,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output otb_pkg::rsp_item_type rsp_item
);
   import otb_pkg::*;

   localparam int LB = $clog2(GRAY_LEVELS);
   localparam int CW = MAX_PIXEL_BITS;       // count width
   localparam int SW = MAX_PIXEL_BITS + 8;   // sum width
   localparam int AW = CW + SW;              // N*m0 width
   localparam int NW = 2 * AW;               // numerator width
   localparam int DW = 2 * CW;               // denominator width
   localparam int PW = NW + DW;              // cross product width
   localparam int XC  = (NW + 31) / 32;      // 32-bit digits, wide operand
   localparam int YC  = (AW + 31) / 32;      // 32-bit digits, narrow operand
   localparam int MIW = (XC > 1) ? $clog2(XC) : 1;
   localparam int MJW = (YC > 1) ? $clog2(YC) : 1;
   localparam logic [CW-1:0] CAP = {CW{1'b1}};
   localparam logic [LB-1:0] TOP_BIN = LB'(GRAY_LEVELS - 1);
   localparam logic [LB:0]   LAST_T  = (LB+1)'(GRAY_LEVELS - 2);

   localparam logic [3:0] ST_RUN   = 4'd0;
   localparam logic [3:0] ST_HUPD  = 4'd1;
   localparam logic [3:0] ST_RD    = 4'd2;
   localparam logic [3:0] ST_ACC   = 4'd3;
   localparam logic [3:0] ST_MUL1  = 4'd4;
   localparam logic [3:0] ST_MUL2  = 4'd5;
   localparam logic [3:0] ST_DIFF  = 4'd6;
   localparam logic [3:0] ST_SQ    = 4'd7;
   localparam logic [3:0] ST_LHS   = 4'd8;
   localparam logic [3:0] ST_RHS   = 4'd9;
   localparam logic [3:0] ST_NEXT  = 4'd10;
   localparam logic [3:0] ST_CLEAR = 4'd11;

   logic [3:0] state_ff, state_in;

   // histogram memory, one write and one registered read per cycle
   logic [CW-1:0] hist_mem [GRAY_LEVELS];
   logic [CW-1:0] rd_ff;
   logic [LB-1:0] raddr, waddr;
   logic          we;
   logic [CW-1:0] wdata;

   logic [CW-1:0] total_ff, total_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [7:0]    thr_ff, thr_in;
   logic [LB:0]   t_ff, t_in;
   logic [CW-1:0] n0_ff, n0_in;
   logic [SW-1:0] m0_ff, m0_in;
   logic [AW-1:0] a_ff, a_in, b_ff, b_in;
   logic [AW-1:0] d_val;
   logic [DW-1:0] den_ff, den_in;
   logic [NW-1:0] num_ff, num_in;
   logic [NW-1:0] bnum_ff, bnum_in;
   logic [DW-1:0] bden_ff, bden_in;
   logic [PW-1:0] lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic [7:0]    best_ff, best_in;
   logic [LB-1:0] bin_ff, bin_in;
   logic          skip_ff, skip_in;
   logic          init_ff, init_in;

   // shared multi-cycle multiplier, one 32x32 partial product a cycle
   logic [32*XC-1:0] mx_ff, mx_in;
   logic [32*YC-1:0] my_ff, my_in;
   logic [PW-1:0]    acc_ff, acc_in;
   logic [MIW-1:0]   mi_ff, mi_in;
   logic [MJW-1:0]   mj_ff, mj_in;
   logic [63:0]      mprod;
   logic [PW-1:0]    macc;
   logic             mlast;

   // output register
   logic          ov_ff, ov_in;
   rsp_item_type  od_ff, od_in;
   logic          out_free;

   assign out_free  = !ov_ff || rsp_pop;
   assign rsp_empty = !ov_ff;
   assign rsp_item  = od_ff;

   logic [LB-1:0] pix_bin;
   assign pix_bin = (q_item.pixel >= 9'(GRAY_LEVELS)) ? TOP_BIN : q_item.pixel[LB-1:0];

   assign d_val = (a_ff >= b_ff) ? a_ff - b_ff : b_ff - a_ff;

   assign mprod = mx_ff[32*mi_ff +: 32] * my_ff[32*mj_ff +: 32];
   assign macc  = acc_ff + (PW'(mprod) << (32 * (int'(mi_ff) + int'(mj_ff))));
   assign mlast = (mi_ff == MIW'(XC - 1)) && (mj_ff == MJW'(YC - 1));

   always_comb begin
      state_in = state_ff;
      total_in = total_ff; sum_in = sum_ff; thr_in = thr_ff;
      t_in = t_ff; n0_in = n0_ff; m0_in = m0_ff;
      a_in = a_ff; b_in = b_ff; den_in = den_ff; num_in = num_ff;
      bnum_in = bnum_ff; bden_in = bden_ff; lhs_in = lhs_ff; rhs_in = rhs_ff;
      best_in = best_ff; bin_in = bin_ff; skip_in = skip_ff; init_in = init_ff;
      mx_in = mx_ff; my_in = my_ff; acc_in = acc_ff; mi_in = mi_ff; mj_in = mj_ff;
      ov_in = ov_ff && !rsp_pop; od_in = od_ff;
      q_take = 1'b0;
      raddr = pix_bin; waddr = bin_ff; we = 1'b0; wdata = rd_ff + 1'b1;
      // multiply step: add one partial product, move to the next digit pair
      if (state_ff == ST_SQ || state_ff == ST_LHS || state_ff == ST_RHS) begin
         acc_in = macc;
         if (mj_ff == MJW'(YC - 1)) begin
            mj_in = '0;
            mi_in = mi_ff + 1'b1;
         end else begin
            mj_in = mj_ff + 1'b1;
         end
      end
      unique case (state_ff)
         ST_RUN: begin
            if (q_valid) begin
               if (q_item.command == CMD_CLASS) begin
                  if (out_free) begin
                     q_take = 1'b1;
                     ov_in  = 1'b1;
                     od_in.result_kind     = KIND_PIXEL;
                     od_in.threshold_level = 8'd0;
                     od_in.binary_pixel    = (q_item.pixel > thr_ff) ? WHITE_LEVEL : 8'd0;
                  end
               end else begin
                  // read bin, update next cycle
                  q_take  = 1'b1;
                  bin_in  = pix_bin;
                  skip_in = (total_ff == CAP);
                  if (!skip_in) begin
                     total_in = total_ff + 1'b1;
                     sum_in   = sum_ff + SW'(pix_bin);
                  end
                  t_in     = {1'b0, q_item.last};
                  state_in = ST_HUPD;
               end
            end
         end
         ST_HUPD: begin
            we = !skip_ff;
            if (t_ff[0]) begin
               t_in = '0; n0_in = '0; m0_in = '0;
               bnum_in = '0; bden_in = DW'(1); best_in = '0;
               state_in = ST_RD;
            end else begin
               state_in = ST_RUN;
            end
         end
         ST_RD: begin
            // wait for last update to land, then read bin t
            raddr    = t_ff[LB-1:0];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            n0_in = n0_ff + rd_ff;
            m0_in = m0_ff + SW'(rd_ff) * SW'(t_ff[LB-1:0]);
            t_in  = t_ff + 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            // a level with an empty class goes straight to the next one
            skip_in = (n0_ff == '0) || (n0_ff >= total_ff);
            a_in   = AW'(total_ff) * AW'(m0_ff);
            den_in = DW'(n0_ff) * DW'(total_ff - n0_ff);
            state_in = skip_in ? ST_NEXT : ST_MUL2;
         end
         ST_MUL2: begin
            b_in = AW'(n0_ff) * AW'(sum_ff);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            // square |a - b|
            mx_in = (32*XC)'(d_val); my_in = (32*YC)'(d_val);
            acc_in = '0; mi_in = '0; mj_in = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            if (mlast) begin
               num_in = macc[NW-1:0];
               mx_in = (32*XC)'(macc[NW-1:0]); my_in = (32*YC)'(bden_ff);
               acc_in = '0; mi_in = '0; mj_in = '0;
               state_in = ST_LHS;
            end
         end
         ST_LHS: begin
            if (mlast) begin
               lhs_in = macc;
               mx_in = (32*XC)'(bnum_ff); my_in = (32*YC)'(den_ff);
               acc_in = '0; mi_in = '0; mj_in = '0;
               state_in = ST_RHS;
            end
         end
         ST_RHS: begin
            if (mlast) begin
               rhs_in = macc;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            // keep the level only on a strictly greater variance
            if (!skip_ff && lhs_ff > rhs_ff) begin
               bnum_in = num_ff; bden_in = den_ff;
               best_in = 8'(t_ff);
            end
            if (t_ff == LAST_T) begin
               bin_in = '0;
               state_in = ST_CLEAR;
            end else begin
               raddr = t_ff[LB-1:0];
               state_in = ST_ACC;
            end
         end
         ST_CLEAR: begin
            // clear sweep, one bin a cycle
            we = 1'b1; waddr = bin_ff; wdata = '0;
            bin_in = bin_ff + 1'b1;
            if (bin_ff == TOP_BIN) begin
               if (init_ff) begin
                  // sweep after reset gives no result
                  init_in = 1'b0;
                  t_in = '0;
                  state_in = ST_RUN;
               end else if (out_free) begin
                  thr_in = best_ff;
                  total_in = '0; sum_in = '0;
                  ov_in = 1'b1;
                  od_in.result_kind     = KIND_THRESHOLD;
                  od_in.threshold_level = best_ff;
                  od_in.binary_pixel    = 8'd0;
                  t_in = '0;
                  state_in = ST_RUN;
               end else begin
                  bin_in = bin_ff;
               end
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         total_ff <= '0; sum_ff <= '0; thr_ff <= '0;
         t_ff <= '0; bin_ff <= '0; ov_ff <= 1'b0; best_ff <= '0;
         init_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in; sum_ff <= sum_in; thr_ff <= thr_in;
         t_ff <= t_in; bin_ff <= bin_in; ov_ff <= ov_in; best_ff <= best_in;
         init_ff <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      n0_ff <= n0_in; m0_ff <= m0_in; a_ff <= a_in; b_ff <= b_in;
      den_ff <= den_in; num_ff <= num_in; bnum_ff <= bnum_in; bden_ff <= bden_in;
      lhs_ff <= lhs_in; rhs_ff <= rhs_in; skip_ff <= skip_in; od_ff <= od_in;
      mx_ff <= mx_in; my_ff <= my_in; acc_ff <= acc_in; mi_ff <= mi_in; mj_ff <= mj_in;
      rd_ff <= hist_mem[raddr];
      if (we) begin
         hist_mem[waddr] <= wdata;
      end
   end
endmodule

// File: hdl/otsu_threshold_binarizer_top.sv
// Top level of the Otsu threshold binarizer.
// Usage: push items on the req_ queue port (push/full), take results from the
// rsp_ queue port (empty/pop). command 0 adds a pixel to the histogram; with
// last set, a threshold search over levels 1..GRAY_LEVELS-2 follows and one
// threshold result is produced. command 1 classifies a pixel against the
// latched threshold and gives one result.
// A classify pixel's result is visible the cycle after the back end takes it,
// one per cycle back to back while each result is popped. A histogram pixel
// is a read-modify-write of the bin memory, read in ST_RUN and written in ST_HUPD.
// The search then visits each level in turn: a level with an empty class
// passes through ST_ACC, ST_MUL1 and ST_NEXT only; any other level also forms three
// products from 32x32 partial products on one shared multiplier. A sweep then clears
// the histogram memory; the threshold is emitted on its last bin once the output is free.
// A two-entry input queue decouples the front from the back end; the output
// register holds a result until popped, and a back end with a new result stalls meanwhile.
// After reset a clearing pass over all GRAY_LEVELS bins runs before any item is
// processed and gives no result; pushes still land in the input queue.
module otsu_threshold_binarizer_top #(
   parameter int MAX_PIXEL_BITS = 20,
   parameter int GRAY_LEVELS    = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  otb_pkg::req_item_type req_item,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output otb_pkg::rsp_item_type rsp_item
);
   import otb_pkg::*;

   logic         q_valid, q_take;
   req_item_type q_item;

   otb_front u_front (
      .clock, .reset, .req_push, .req_full, .req_item,
      .q_valid, .q_item, .q_take
   );

   otb_back #(.MAX_PIXEL_BITS(MAX_PIXEL_BITS), .GRAY_LEVELS(GRAY_LEVELS)) u_back (
      .clock, .reset, .q_valid, .q_item, .q_take,
      .rsp_empty, .rsp_pop, .rsp_item
   );
endmodule

// File: hdl/otb_checker.sv
// Port-level checker for the Otsu threshold binarizer, bound to the top.
module otb_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_push,
   input logic                  req_full,
   input otb_pkg::req_item_type req_item,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input otb_pkg::rsp_item_type rsp_item
);
   import otb_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_item)))
      else $error("result changed while stalled");

   a_pix_val: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.result_kind == KIND_PIXEL) |->
      (rsp_item.binary_pixel == 8'd0 || rsp_item.binary_pixel == WHITE_LEVEL))
      else $error("bad binary pixel");

   a_thr_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.result_kind == KIND_THRESHOLD) |->
      (rsp_item.binary_pixel == 8'd0))
      else $error("threshold result with pixel bits");

   a_reset_empty: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> rsp_empty)
      else $error("result after reset");
endmodule

bind otsu_threshold_binarizer_top otb_checker u_otb_checker (.*);
